>>> rtl/core/ols_pkg.sv
// Shared types, codes and constants of the ordered list store.
package ols_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int DATA_W       = 32;
  localparam int POS_W        = 8;
  localparam int FUNC_W       = 3;
  localparam int IPOS_W       = 5;
  localparam int ICNT_W       = 6;
  localparam int STS_W        = 3;

  typedef enum logic [FUNC_W-1:0] {
    FN_INS_POS = 3'd0,
    FN_INS_KEY = 3'd1,
    FN_DEL_POS = 3'd2,
    FN_DEL_VAL = 3'd3,
    FN_SORT    = 3'd4,
    FN_READ    = 3'd5
  } func_t;

  typedef enum logic [STS_W-1:0] {
    STS_OK     = 3'd0,
    STS_EMPTY  = 3'd1,
    STS_BADPOS = 3'd2,
    STS_NOKEY  = 3'd3,
    STS_FULL   = 3'd4
  } sts_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_MATCH,
    ST_APPLY,
    ST_SORT,
    ST_READ,
    ST_RESP
  } state_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_SHR,
    OP_SHL,
    OP_ROT,
    OP_SORT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     take;
    logic     alt;
  } cell_ctl_t;

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] key;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] item_value;
    logic [IPOS_W-1:0]        item_position;
    logic [ICNT_W-1:0]        item_count;
    logic [STS_W-1:0]         status;
    logic                     last;
  } rsp_t;

endpackage

>>> rtl/core/ols_cell.sv
// One storage cell of the list chain: holds one element and trades with its neighbors.
module ols_cell (
  input  logic                              clk,
  input  ols_pkg::cell_ctl_t                ctl_i,
  input  logic signed [ols_pkg::DATA_W-1:0] left_i,
  input  logic signed [ols_pkg::DATA_W-1:0] right_i,
  input  logic signed [ols_pkg::DATA_W-1:0] ext_i,
  input  logic signed [ols_pkg::DATA_W-1:0] cmp_i,
  input  logic                              left_gt_i,
  output logic signed [ols_pkg::DATA_W-1:0] data_o,
  output logic                              gt_o,
  output logic                              eq_o
);

  logic signed [ols_pkg::DATA_W-1:0] data_r;
  logic signed [ols_pkg::DATA_W-1:0] data_nxt;

  assign data_o = data_r;
  assign gt_o   = data_r > right_i;
  assign eq_o   = data_r == cmp_i;

  always_comb begin
    data_nxt = data_r;
    case (ctl_i.op)
      ols_pkg::OP_SHR: begin
        if (ctl_i.take) data_nxt = ctl_i.alt ? ext_i : left_i;
      end
      ols_pkg::OP_SHL: begin
        if (ctl_i.take) data_nxt = right_i;
      end
      ols_pkg::OP_ROT: begin
        if (ctl_i.take) data_nxt = ctl_i.alt ? ext_i : right_i;
      end
      ols_pkg::OP_SORT: begin
        // A cell is either the lower or the upper half of a pair in one phase.
        if (ctl_i.take && gt_o) begin
          data_nxt = right_i;
        end else if (ctl_i.alt && left_gt_i) begin
          data_nxt = left_i;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

>>> rtl/core/ordered_list_store.sv
// Ordered list store: a chain of value cells driven by a request sequencer.
//
// Requests enter on in_valid/in_stall with an in_req payload; results leave on
// out_valid/out_stall with an out_rsp payload. A request is taken only while the
// sequencer is idle, so one request is in work at a time; the next one is taken
// while the last result of the previous one may still sit in the output register.
// Insert and delete at a position shift the chain in the dispatch state, then
// the result register is loaded. Insert after a key and delete of a value go
// through match and apply states: the cells compare in parallel, the first
// match is picked, and the chain shifts once. Sort runs CAPACITY odd-even
// compare-exchange phases over the chain. Read gives one element per cycle
// while the output register is free: the chain rotates by one each time and
// the head cell gives the element, so after count steps the list is back in
// order. Every other request gives one result. After loading the last result
// the sequencer returns to idle, where the next request is taken.
// A stalled receiver holds the output register; the sequencer then waits.
// Reset empties the list (count zero) and returns to idle; cell contents are
// not cleared and are only read below the count.
module ordered_list_store #(
  parameter int CAPACITY = ols_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  ols_pkg::req_t in_req,
  output logic          out_valid,
  input  logic          out_stall,
  output ols_pkg::rsp_t out_rsp
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);

  ols_pkg::state_t state_r, state_nxt;
  ols_pkg::req_t   req_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  ols_pkg::sts_t   status_r, status_nxt;
  logic [IDX_W-1:0] phase_r, phase_nxt;
  logic [IDX_W-1:0] rd_r, rd_nxt;
  logic [CAPACITY-1:0] match_r;
  ols_pkg::rsp_t   out_r, out_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_load;

  logic do_ins, do_del_pos, do_ins_key, do_del_val, do_sort, do_rot;
  logic slot_free;
  logic [ols_pkg::POS_W-1:0] ins_at;

  logic signed [ols_pkg::DATA_W-1:0] cell_data [CAPACITY];
  logic [CAPACITY-1:0] cell_gt;
  logic [CAPACITY-1:0] cell_eq;
  logic [CAPACITY-1:0] below;
  ols_pkg::cell_ctl_t  ctl [CAPACITY];

  logic [CAPACITY-1:0] first;
  logic [CAPACITY-1:0] before_first;
  logic [CAPACITY-1:0] above;
  logic [CAPACITY-1:0] ins_pt;
  logic signed [ols_pkg::DATA_W-1:0] ext_data;
  logic signed [ols_pkg::DATA_W-1:0] cmp_data;

  assign in_stall  = (state_r != ols_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_r;
  assign slot_free = !out_valid_r || !out_stall;

  // Lowest set bit of the match vector marks the first equal element.
  assign first        = match_r & (~match_r + 1'b1);
  assign before_first = first - 1'b1;
  assign above        = ~(first | before_first);
  assign ins_pt       = first << 1;

  assign ins_at   = (cnt_r == '0) ? '0 : req_r.position;
  assign ext_data = do_rot ? cell_data[0] : req_r.value;
  assign cmp_data = (req_r.func == ols_pkg::FN_INS_KEY) ? req_r.key : req_r.value;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      below[i] = CNT_W'(i) < cnt_r;
    end
  end

  // Request sequencer.
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    status_nxt = status_r;
    phase_nxt  = phase_r;
    rd_nxt     = rd_r;
    out_load   = 1'b0;
    out_nxt    = '0;
    do_ins     = 1'b0;
    do_del_pos = 1'b0;
    do_ins_key = 1'b0;
    do_del_val = 1'b0;
    do_sort    = 1'b0;
    do_rot     = 1'b0;
    case (state_r)
      ols_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = ols_pkg::ST_DISPATCH;
      end
      ols_pkg::ST_DISPATCH: begin
        status_nxt = ols_pkg::STS_OK;
        state_nxt  = ols_pkg::ST_RESP;
        case (req_r.func)
          ols_pkg::FN_INS_POS: begin
            if (cnt_r == '0) begin
              do_ins  = 1'b1;
              cnt_nxt = cnt_r + 1'b1;
            end else if (cnt_r >= CNT_W'(CAPACITY)) begin
              status_nxt = ols_pkg::STS_FULL;
            end else if (req_r.position > ols_pkg::POS_W'(cnt_r)) begin
              status_nxt = ols_pkg::STS_BADPOS;
            end else begin
              do_ins  = 1'b1;
              cnt_nxt = cnt_r + 1'b1;
            end
          end
          ols_pkg::FN_INS_KEY: begin
            if (cnt_r == '0) begin
              do_ins  = 1'b1;
              cnt_nxt = cnt_r + 1'b1;
            end else if (cnt_r >= CNT_W'(CAPACITY)) begin
              status_nxt = ols_pkg::STS_FULL;
            end else begin
              state_nxt = ols_pkg::ST_MATCH;
            end
          end
          ols_pkg::FN_DEL_POS: begin
            if (cnt_r == '0) begin
              status_nxt = ols_pkg::STS_EMPTY;
            end else if (req_r.position >= ols_pkg::POS_W'(cnt_r)) begin
              status_nxt = ols_pkg::STS_BADPOS;
            end else begin
              do_del_pos = 1'b1;
              cnt_nxt    = cnt_r - 1'b1;
            end
          end
          ols_pkg::FN_DEL_VAL: begin
            if (cnt_r == '0) status_nxt = ols_pkg::STS_EMPTY;
            else state_nxt = ols_pkg::ST_MATCH;
          end
          ols_pkg::FN_SORT: begin
            if (cnt_r == '0) begin
              status_nxt = ols_pkg::STS_EMPTY;
            end else begin
              phase_nxt = '0;
              state_nxt = ols_pkg::ST_SORT;
            end
          end
          ols_pkg::FN_READ: begin
            if (cnt_r == '0) begin
              status_nxt = ols_pkg::STS_EMPTY;
            end else begin
              rd_nxt    = '0;
              state_nxt = ols_pkg::ST_READ;
            end
          end
          default: status_nxt = ols_pkg::STS_OK;
        endcase
      end
      ols_pkg::ST_MATCH: begin
        state_nxt = ols_pkg::ST_APPLY;
      end
      ols_pkg::ST_APPLY: begin
        state_nxt = ols_pkg::ST_RESP;
        if (match_r == '0) begin
          status_nxt = ols_pkg::STS_NOKEY;
        end else if (req_r.func == ols_pkg::FN_INS_KEY) begin
          do_ins_key = 1'b1;
          cnt_nxt    = cnt_r + 1'b1;
        end else begin
          do_del_val = 1'b1;
          cnt_nxt    = cnt_r - 1'b1;
        end
      end
      ols_pkg::ST_SORT: begin
        do_sort   = 1'b1;
        phase_nxt = phase_r + 1'b1;
        if (phase_r == IDX_W'(CAPACITY - 1)) state_nxt = ols_pkg::ST_RESP;
      end
      ols_pkg::ST_READ: begin
        if (slot_free) begin
          do_rot                = 1'b1;
          out_load              = 1'b1;
          out_nxt.item_value    = cell_data[0];
          out_nxt.item_position = ols_pkg::IPOS_W'(rd_r);
          out_nxt.item_count    = ols_pkg::ICNT_W'(cnt_r);
          out_nxt.status        = ols_pkg::STS_OK;
          out_nxt.last          = (CNT_W'(rd_r) == cnt_r - 1'b1);
          rd_nxt                = rd_r + 1'b1;
          if (out_nxt.last) state_nxt = ols_pkg::ST_IDLE;
        end
      end
      ols_pkg::ST_RESP: begin
        if (slot_free) begin
          out_load           = 1'b1;
          out_nxt.item_count = ols_pkg::ICNT_W'(cnt_r);
          out_nxt.status     = status_r;
          out_nxt.last       = 1'b1;
          state_nxt          = ols_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ols_pkg::ST_IDLE;
    endcase
  end

  // Per-cell control from the current operation.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ctl[i] = '{op: ols_pkg::OP_HOLD, take: 1'b0, alt: 1'b0};
      if (do_ins) begin
        ctl[i] = '{op: ols_pkg::OP_SHR, take: ols_pkg::POS_W'(i) >= ins_at,
                   alt: ols_pkg::POS_W'(i) == ins_at};
      end else if (do_del_pos) begin
        ctl[i] = '{op: ols_pkg::OP_SHL, take: ols_pkg::POS_W'(i) >= req_r.position,
                   alt: 1'b0};
      end else if (do_ins_key) begin
        ctl[i] = '{op: ols_pkg::OP_SHR, take: above[i], alt: ins_pt[i]};
      end else if (do_del_val) begin
        ctl[i] = '{op: ols_pkg::OP_SHL, take: !before_first[i], alt: 1'b0};
      end else if (do_sort) begin
        ctl[i] = '{op: ols_pkg::OP_SORT,
                   take: (1'(i % 2) == phase_r[0]) && (CNT_W'(i + 1) < cnt_r),
                   alt: (i >= 1) && (1'((i + 1) % 2) == phase_r[0]) && below[i]};
      end else if (do_rot) begin
        ctl[i] = '{op: ols_pkg::OP_ROT, take: below[i],
                   alt: CNT_W'(i) == cnt_r - 1'b1};
      end
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [ols_pkg::DATA_W-1:0] left_d;
    logic signed [ols_pkg::DATA_W-1:0] right_d;
    logic                              left_gt;
    if (g == 0) begin : g_head
      assign left_d  = '0;
      assign left_gt = 1'b0;
    end else begin : g_mid
      assign left_d  = cell_data[g-1];
      assign left_gt = cell_gt[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign right_d = '0;
    end else begin : g_body
      assign right_d = cell_data[g+1];
    end
    ols_cell u_cell (
      .clk       (clk),
      .ctl_i     (ctl[g]),
      .left_i    (left_d),
      .right_i   (right_d),
      .ext_i     (ext_data),
      .cmp_i     (cmp_data),
      .left_gt_i (left_gt),
      .data_o    (cell_data[g]),
      .gt_o      (cell_gt[g]),
      .eq_o      (cell_eq[g])
    );
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ols_pkg::ST_IDLE;
      cnt_r       <= '0;
      status_r    <= ols_pkg::STS_OK;
      phase_r     <= '0;
      rd_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      status_r    <= status_nxt;
      phase_r     <= phase_nxt;
      rd_r        <= rd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) req_r <= in_req;
    if (state_r == ols_pkg::ST_MATCH) match_r <= cell_eq & below;
    if (out_load) out_r <= out_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("element count above capacity");

  a_sort_keeps_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ols_pkg::ST_SORT |=> $stable(cnt_r))
    else $error("count changed during sort");

  a_only_read_streams: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.last |-> out_r.status == ols_pkg::STS_OK)
    else $error("non-final result with a failing status");

  a_match_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ols_pkg::ST_APPLY |-> (match_r & ~below) == '0)
    else $error("match outside the stored elements");

endmodule
